>>> sv/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded deque with value removal.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int VALUE_W       = 32;
  localparam int COUNT_W       = 5;

  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_REMOVE     = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

endpackage

>>> sv/bounded_deque_with_value_removal.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_value_removal
// Double-ended queue of signed 32-bit words in a circular RAM with a head
// index and a count; push/pop at either end and removal of the first match.
// ----------------------------------------------------------------------------
// Requests are taken when start is high and busy is low; each request gives
// one result, shown for one cycle with done high. The receiver cannot stall,
// so capture the result in that cycle. Pops read the new end word from the
// RAM, whose read data is registered; pushes, and pops that empty the queue,
// need no read. A value removal walks the queue from the front one word per
// cycle, then shifts the later words forward one per cycle and reads back
// both ends, unless the removal empties the queue. The walk stops at the
// last word when no match is found, and an empty queue gives ST_EMPTY with
// no walk. No clearing pass follows reset.
module bounded_deque_with_value_removal
  import bdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  req_type,
  input  logic signed [VALUE_W-1:0]   item_value,
  output logic                        done,
  output logic signed [VALUE_W-1:0]   front_value,
  output logic signed [VALUE_W-1:0]   back_value,
  output logic [COUNT_W-1:0]          entry_count,
  output logic                        is_empty,
  output logic [1:0]                  status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_CAPF,
    S_CAPB
  } state_t;

  state_t              state;
  logic [AW-1:0]       head;
  logic [CW-1:0]       count;
  logic [CW-1:0]       pos;
  logic                both;
  logic [VALUE_W-1:0]  front;
  logic [VALUE_W-1:0]  back;
  logic [VALUE_W-1:0]  val;
  status_t             status_q;

  logic                we;
  logic [AW-1:0]       waddr;
  logic [AW-1:0]       raddr;
  logic [VALUE_W-1:0]  wdata;
  logic [VALUE_W-1:0]  rdata;
  logic                full;
  logic                accept;
  logic [AW-1:0]       head_dec;

  // physical slot of a logical position, sum stays below twice the depth
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h,
                                         input logic [CW-1:0] p);
    logic [AW:0] s;
    s = (AW+1)'(h) + (AW+1)'(p);
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign full     = (count == CW'(DEPTH));
  assign accept   = start && (state == S_IDLE);
  assign busy     = (state != S_IDLE);
  assign head_dec = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);

  bdq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // ram port control
  always_comb begin
    we    = 1'b0;
    waddr = head;
    wdata = item_value;
    raddr = head;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (req_type)
            REQ_PUSH_FRONT: begin
              we    = !full;
              waddr = head_dec;
            end
            REQ_PUSH_BACK: begin
              we    = !full;
              waddr = slot(head, count);
            end
            REQ_POP_FRONT: begin
              raddr = slot(head, CW'(1));
            end
            REQ_POP_BACK: begin
              if (count > CW'(1)) begin
                raddr = slot(head, count - CW'(2));
              end
            end
            default: begin
              raddr = head;
            end
          endcase
        end
      end
      S_SEARCH: begin
        raddr = slot(head, pos + CW'(1));
      end
      S_SHIFT: begin
        if (pos + CW'(1) < count) begin
          we    = 1'b1;
          waddr = slot(head, pos);
          wdata = rdata;
          raddr = slot(head, pos + CW'(2));
        end
      end
      S_CAPF: begin
        if (count != '0) begin
          raddr = slot(head, count - CW'(1));
        end
      end
      S_CAPB: begin
        raddr = head;
      end
      default: begin
        raddr = head;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            val      <= item_value;
            status_q <= ST_DONE;
            unique case (req_type)
              REQ_PUSH_FRONT: begin
                done <= 1'b1;
                if (full) begin
                  status_q <= ST_FULL;
                end else begin
                  head  <= head_dec;
                  count <= count + CW'(1);
                  front <= item_value;
                  if (count == '0) begin
                    back <= item_value;
                  end
                end
              end
              REQ_PUSH_BACK: begin
                done <= 1'b1;
                if (full) begin
                  status_q <= ST_FULL;
                end else begin
                  count <= count + CW'(1);
                  back  <= item_value;
                  if (count == '0) begin
                    front <= item_value;
                  end
                end
              end
              REQ_POP_FRONT: begin
                if (count == '0) begin
                  status_q <= ST_EMPTY;
                  done     <= 1'b1;
                end else begin
                  head  <= slot(head, CW'(1));
                  count <= count - CW'(1);
                  both  <= 1'b0;
                  if (count == CW'(1)) begin
                    done <= 1'b1;
                  end else begin
                    state <= S_CAPF;
                  end
                end
              end
              REQ_POP_BACK: begin
                if (count == '0) begin
                  status_q <= ST_EMPTY;
                  done     <= 1'b1;
                end else begin
                  count <= count - CW'(1);
                  if (count == CW'(1)) begin
                    done <= 1'b1;
                  end else begin
                    state <= S_CAPB;
                  end
                end
              end
              REQ_REMOVE: begin
                if (count == '0) begin
                  status_q <= ST_EMPTY;
                  done     <= 1'b1;
                end else begin
                  pos   <= '0;
                  both  <= 1'b1;
                  state <= S_SEARCH;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_SEARCH: begin
          // rdata holds the word at logical position pos
          if (rdata == val) begin
            state <= S_SHIFT;
          end else if (pos == count - CW'(1)) begin
            status_q <= ST_NOT_FOUND;
            done     <= 1'b1;
            state    <= S_IDLE;
          end else begin
            pos <= pos + CW'(1);
          end
        end
        S_SHIFT: begin
          if (pos + CW'(1) < count) begin
            pos <= pos + CW'(1);
          end else begin
            count <= count - CW'(1);
            if (count == CW'(1)) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              state <= S_CAPF;
            end
          end
        end
        S_CAPF: begin
          front <= rdata;
          if (both) begin
            state <= S_CAPB;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_CAPB: begin
          back  <= rdata;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign is_empty    = (count == '0);
  assign front_value = is_empty ? '0 : front;
  assign back_value  = is_empty ? '0 : back;
  assign entry_count = COUNT_W'(count);
  assign status      = status_q;

endmodule

>>> sv/bdq_ram.sv
// ----------------------------------------------------------------------------
// bdq_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> bench/bounded_deque_with_value_removal_test.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_value_removal_test
// Self-checking bench for the bounded deque. A scoreboard class keeps its own
// circular store, head and count, and predicts the result word of every
// accepted request. Directed corner requests run first, then phases of biased
// random traffic (filling, draining, removal heavy, even) with random pacing.
// ----------------------------------------------------------------------------
module bounded_deque_with_value_removal_test;
  import bdq_pkg::*;

  localparam int DEPTH         = DEPTH_DEFAULT;
  localparam int PHASES        = 9;
  localparam int PHASE_WORDS   = 150;
  localparam int STALL_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 2 * DEPTH + 8;

  // request codes the block treats as no-ops
  localparam logic [2:0] REQ_SPARE_5 = 3'd5;
  localparam logic [2:0] REQ_SPARE_6 = 3'd6;
  localparam logic [2:0] REQ_SPARE_7 = 3'd7;

  localparam logic signed [VALUE_W-1:0] WORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [VALUE_W-1:0] WORD_MIN = 32'sh8000_0000;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_REMOVE, MIX_EVEN} mix_t;
  typedef enum {PACE_NONE, PACE_RANDOM, PACE_BURSTY} pace_t;

  typedef struct {
    logic signed [VALUE_W-1:0] front;
    logic signed [VALUE_W-1:0] back;
    logic [COUNT_W-1:0]        count;
    logic                      empty;
    status_t                   status;
  } deque_view_t;

  class deque_tracker;
    logic signed [VALUE_W-1:0] slots [DEPTH];
    int head;
    int count;
    int mismatches;
    deque_view_t expected_views [$];

    function new();
      head = 0;
      count = 0;
      mismatches = 0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    function logic signed [VALUE_W-1:0] value_at(int pos);
      return slots[(head + pos) % DEPTH];
    endfunction

    function int pending();
      return expected_views.size();
    endfunction

    function void note_request(logic [2:0] req, logic signed [VALUE_W-1:0] value);
      deque_view_t view;
      status_t st;
      int hit;
      st = ST_DONE;
      case (req)
        REQ_PUSH_FRONT: begin
          if (count >= DEPTH) begin
            st = ST_FULL;
          end else begin
            head = (head + DEPTH - 1) % DEPTH;
            slots[head] = value;
            count++;
          end
        end
        REQ_PUSH_BACK: begin
          if (count >= DEPTH) begin
            st = ST_FULL;
          end else begin
            slots[(head + count) % DEPTH] = value;
            count++;
          end
        end
        REQ_POP_FRONT: begin
          if (count == 0) begin
            st = ST_EMPTY;
          end else begin
            head = (head + 1) % DEPTH;
            count--;
          end
        end
        REQ_POP_BACK: begin
          if (count == 0) begin
            st = ST_EMPTY;
          end else begin
            count--;
          end
        end
        REQ_REMOVE: begin
          if (count == 0) begin
            st = ST_EMPTY;
          end else begin
            hit = -1;
            for (int i = 0; i < count && hit < 0; i++)
              if (value_at(i) === value) hit = i;
            if (hit < 0) begin
              st = ST_NOT_FOUND;
            end else begin
              // close the gap toward the front
              for (int i = hit; i + 1 < count; i++)
                slots[(head + i) % DEPTH] = value_at(i + 1);
              count--;
            end
          end
        end
        default: ;
      endcase
      view.empty  = (count == 0);
      view.front  = view.empty ? '0 : value_at(0);
      view.back   = view.empty ? '0 : value_at(count - 1);
      view.count  = COUNT_W'(count);
      view.status = st;
      expected_views.push_back(view);
    endfunction

    function void compare_field(string name, logic signed [VALUE_W-1:0] want,
                                logic signed [VALUE_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(logic signed [VALUE_W-1:0] front,
                               logic signed [VALUE_W-1:0] back,
                               logic [COUNT_W-1:0] cnt, logic empty, logic [1:0] st);
      deque_view_t want;
      if (expected_views.size() == 0) begin
        $error("result word with no request outstanding");
        mismatches++;
        return;
      end
      want = expected_views.pop_front();
      compare_field("front_value", want.front, front);
      compare_field("back_value", want.back, back);
      compare_field("entry_count", want.count, cnt);
      compare_field("is_empty", want.empty, empty);
      compare_field("status", want.status, st);
    endfunction
  endclass

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic [2:0]                req_type = '0;
  logic signed [VALUE_W-1:0] item_value = '0;
  logic                      busy;
  logic                      done;
  logic signed [VALUE_W-1:0] front_value;
  logic signed [VALUE_W-1:0] back_value;
  logic [COUNT_W-1:0]        entry_count;
  logic                      is_empty;
  logic [1:0]                status;
  int                        idle_cycles = 0;

  deque_tracker tracker = new();

  bounded_deque_with_value_removal #(.DEPTH(DEPTH)) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .item_value(item_value),
    .done(done),
    .front_value(front_value),
    .back_value(back_value),
    .entry_count(entry_count),
    .is_empty(is_empty),
    .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // check before noting, so a result is always matched against an older word
  always @(posedge clk) begin
    if (!rst) begin
      if (done)
        tracker.check_result(front_value, back_value, entry_count, is_empty, status);
      if (start && busy === 1'b0)
        tracker.note_request(req_type, item_value);
      if ((start && busy === 1'b0) || done)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(negedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  // start stays high across back-to-back words; it drops only for a gap
  task automatic send_request(input logic [2:0] req, input logic signed [VALUE_W-1:0] value,
                              input int gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start      <= 1'b1;
    req_type   <= req;
    item_value <= value;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  function automatic logic signed [VALUE_W-1:0] random_word();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return $urandom;
      // narrow range so removals hit duplicates
      5, 6, 7:       return $urandom_range(7) - 3;
      8:             return WORD_MAX;
      default:       return WORD_MIN;
    endcase
  endfunction

  function automatic void pick_request(input mix_t mix, output logic [2:0] req,
                                       output logic signed [VALUE_W-1:0] value);
    int roll;
    int push_pct;
    int pop_pct;
    case (mix)
      MIX_FILL: begin
        push_pct = 70;
        pop_pct  = 12;
      end
      MIX_DRAIN: begin
        push_pct = 25;
        pop_pct  = 50;
      end
      MIX_REMOVE: begin
        push_pct = 45;
        pop_pct  = 10;
      end
      default: begin
        push_pct = 40;
        pop_pct  = 30;
      end
    endcase
    roll  = $urandom_range(99);
    value = random_word();
    if (roll < push_pct) begin
      req = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
    end else if (roll < push_pct + pop_pct) begin
      req = $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
    end else if (roll < 97) begin
      req = REQ_REMOVE;
      // mostly remove something that is actually stored
      if (tracker.count > 0 && $urandom_range(9) < 7)
        value = tracker.value_at($urandom_range(tracker.count - 1));
    end else begin
      case ($urandom_range(2))
        0:       req = REQ_SPARE_5;
        1:       req = REQ_SPARE_6;
        default: req = REQ_SPARE_7;
      endcase
    end
  endfunction

  initial begin
    logic [2:0]                req;
    logic signed [VALUE_W-1:0] value;
    int                        gap;
    mix_t                      mix;
    pace_t                     pace;

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // empty queue corners
    send_request(REQ_POP_FRONT, '0, 0);
    send_request(REQ_POP_BACK, '0, 0);
    send_request(REQ_REMOVE, 32'sd9, 0);
    send_request(REQ_SPARE_5, '0, 0);
    // extremes at both ends: 5, min, max, -1, 0
    send_request(REQ_PUSH_BACK, WORD_MAX, 0);
    send_request(REQ_PUSH_FRONT, WORD_MIN, 0);
    send_request(REQ_PUSH_BACK, -32'sd1, 0);
    send_request(REQ_PUSH_BACK, '0, 0);
    send_request(REQ_PUSH_FRONT, 32'sd5, 0);
    send_request(REQ_REMOVE, 32'sd12345, 0);
    // removal from the middle, the front and the back
    send_request(REQ_REMOVE, WORD_MAX, 0);
    send_request(REQ_REMOVE, 32'sd5, 0);
    send_request(REQ_REMOVE, '0, 0);
    send_request(REQ_SPARE_6, -32'sd1, 0);
    send_request(REQ_SPARE_7, WORD_MAX, 0);
    send_request(REQ_POP_FRONT, '0, 0);
    send_request(REQ_POP_BACK, '0, 0);
    send_request(REQ_PUSH_FRONT, -32'sd1, 0);
    send_request(REQ_REMOVE, -32'sd1, 0);
    wait_drained();

    for (int phase = 0; phase < PHASES; phase++) begin
      mix = mix_t'(phase % 4);
      if (phase == 0)
        pace = PACE_NONE;
      else if (phase == 1)
        pace = PACE_RANDOM;
      else
        pace = pace_t'($urandom_range(2));
      for (int n = 0; n < PHASE_WORDS; n++) begin
        pick_request(mix, req, value);
        case (pace)
          PACE_NONE:   gap = 0;
          PACE_RANDOM: gap = $urandom_range(15);
          default:     gap = ($urandom_range(7) == 0) ? $urandom_range(15) : 0;
        endcase
        if ($urandom_range(99) == 0)
          wait_drained();
        send_request(req, value, gap);
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
